// ----- src/bounded_l1_ball_lattice_enumerator_assert.svh -----
// Assertion macros used by the checker file.
`ifndef BOUNDED_L1_BALL_LATTICE_ENUMERATOR_ASSERT_SVH
`define BOUNDED_L1_BALL_LATTICE_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BL1E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BL1E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bl1e_pkg.sv -----
`timescale 1ns / 1ps
package bl1e_pkg;

	localparam int DEF_COORDS     = 8;
	localparam int DEF_STEP_WIDTH = 16;

	localparam int GROUP_W    = 4;
	localparam int BUDGET_W   = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int KIND_W     = 2;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t OP_LOAD    = 2'd0;
	localparam kind_t OP_RESTART = 2'd1;
	localparam kind_t OP_EMIT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GROUP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd1;

	localparam logic [GROUP_W-1:0] GROUP_RESET = 4'd8;

	typedef struct packed {
		logic [GROUP_W-1:0]  group_count;
		logic [BUDGET_W-1:0] budget_steps;
	} cfg_t;

endpackage

// ----- src/bl1e_cmd_fifo.sv -----
`timescale 1ns / 1ps
module bl1e_cmd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/bl1e_front.sv -----
`timescale 1ns / 1ps
module bl1e_front
	import bl1e_pkg::*;
#(
	parameter int COORDS     = DEF_COORDS,
	parameter int STEP_WIDTH = DEF_STEP_WIDTH,
	parameter int IDX_W      = (COORDS > 1) ? $clog2(COORDS) : 1,
	parameter int IN_W       = ((KIND_W + IDX_W + 2 * STEP_WIDTH + 7) / 8) * 8,
	parameter int CMD_W      = KIND_W + IDX_W + 2 * STEP_WIDTH
) (
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             q_full,
	output logic             q_push,
	output logic [CMD_W-1:0] q_data
);

	kind_t           op;
	logic [IDX_W-1:0] idx;
	logic            keep;

	assign op  = s_tdata[KIND_W-1:0];
	assign idx = s_tdata[KIND_W +: IDX_W];

	// drop unused codes and loads aimed past the last coordinate
	always_comb begin
		unique case (op)
			OP_LOAD:    keep = ({1'b0, idx} < (IDX_W + 1)'(COORDS));
			OP_RESTART: keep = 1'b1;
			OP_EMIT:    keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign s_tready = ~q_full;
	assign q_push   = s_tvalid & s_tready & keep;
	assign q_data   = s_tdata[CMD_W-1:0];

endmodule

// ----- src/bl1e_back.sv -----
`timescale 1ns / 1ps
module bl1e_back
	import bl1e_pkg::*;
#(
	parameter int COORDS     = DEF_COORDS,
	parameter int STEP_WIDTH = DEF_STEP_WIDTH,
	parameter int IDX_W      = (COORDS > 1) ? $clog2(COORDS) : 1,
	parameter int CMD_W      = KIND_W + IDX_W + 2 * STEP_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	input  logic [CMD_W-1:0]      cmd_data,
	input  cfg_t                  cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      out_index,
	output logic [STEP_WIDTH:0]   out_step,
	output logic                  out_last,
	output logic                  out_exh
);

	localparam int CNT_W = STEP_WIDTH + 1;
	localparam int SUM_W = ((BUDGET_W > CNT_W) ? BUDGET_W : CNT_W) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_UP   = 2'd2;
	localparam logic [1:0] ST_DN   = 2'd3;

	logic [1:0]            state_q;
	logic [IDX_W-1:0]      ptr_q;
	logic                  exh_pend_q;
	logic                  done_q;
	logic [BUDGET_W-1:0]   used_q;
	logic [CNT_W-1:0]      step_q   [COORDS];
	logic                  rising_q [COORDS];
	logic [STEP_WIDTH-1:0] upper_q  [COORDS];
	logic [STEP_WIDTH-1:0] lower_q  [COORDS];

	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_index_q;
	logic [CNT_W-1:0]      out_step_q;
	logic                  out_last_q;
	logic                  out_exh_q;

	kind_t                 cmd_kind;
	logic [IDX_W-1:0]      cmd_idx;
	logic [STEP_WIDTH-1:0] cmd_up;
	logic [STEP_WIDTH-1:0] cmd_lo;

	logic [IDX_W-1:0]      last_idx;
	logic                  out_free;
	logic [CNT_W-1:0]      cur;
	logic [CNT_W-1:0]      cur_mag;
	logic [CNT_W-1:0]      up_cnt;
	logic [CNT_W-1:0]      dn_mag;
	logic [SUM_W-1:0]      used_inc;
	logic [SUM_W-1:0]      used_up_roll;
	logic [SUM_W-1:0]      used_dn_roll;
	logic                  over_budget;
	logic                  roll_up;
	logic                  roll_dn;

	assign cmd_kind = cmd_data[KIND_W-1:0];
	assign cmd_idx  = cmd_data[KIND_W +: IDX_W];
	assign cmd_up   = cmd_data[KIND_W + IDX_W +: STEP_WIDTH];
	assign cmd_lo   = cmd_data[KIND_W + IDX_W + STEP_WIDTH +: STEP_WIDTH];

	assign cmd_pop  = (state_q == ST_IDLE) & cmd_valid;
	assign out_free = ~out_valid_q | out_ready;

	// zero coordinates act as one, too many act as COORDS
	always_comb begin
		priority if (cfg.group_count == '0) begin
			last_idx = '0;
		end else if (32'(cfg.group_count) > 32'(COORDS)) begin
			last_idx = IDX_W'(COORDS - 1);
		end else begin
			last_idx = IDX_W'(cfg.group_count - 4'd1);
		end
	end

	// one odometer digit at a time: the up half, then the down half
	always_comb begin
		cur          = step_q[ptr_q];
		cur_mag      = -cur;
		up_cnt       = cur + CNT_W'(1);
		dn_mag       = cur_mag + CNT_W'(1);
		used_inc     = SUM_W'(used_q) + SUM_W'(1);
		over_budget  = used_inc > SUM_W'(cfg.budget_steps);
		used_up_roll = SUM_W'(used_q) - SUM_W'(cur);
		used_dn_roll = SUM_W'(used_q) - SUM_W'(cur_mag);
		roll_up      = (up_cnt >= CNT_W'(upper_q[ptr_q])) | over_budget;
		roll_dn      = (dn_mag >= CNT_W'(lower_q[ptr_q])) | over_budget;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_kind == OP_LOAD) begin
			upper_q[cmd_idx] <= cmd_up;
			lower_q[cmd_idx] <= cmd_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			if (exh_pend_q) begin
				out_index_q <= '0;
				out_step_q  <= '0;
				out_last_q  <= 1'b1;
				out_exh_q   <= 1'b1;
			end else begin
				out_index_q <= ptr_q;
				out_step_q  <= step_q[ptr_q];
				out_last_q  <= (ptr_q == last_idx);
				out_exh_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			exh_pend_q  <= 1'b0;
			done_q      <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < COORDS; k++) begin
				step_q[k]   <= '0;
				rising_q[k] <= 1'b1;
			end
		end else begin
			// in ST_EMIT a taken beat is replaced by the next one below
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd_kind)
							OP_RESTART: begin
								used_q <= '0;
								done_q <= 1'b0;
								for (int k = 0; k < COORDS; k++) begin
									step_q[k]   <= '0;
									rising_q[k] <= 1'b1;
								end
							end
							OP_EMIT: begin
								exh_pend_q <= done_q;
								ptr_q      <= '0;
								state_q    <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (exh_pend_q) begin
							state_q <= ST_IDLE;
						end else if (ptr_q == last_idx) begin
							ptr_q   <= '0;
							state_q <= ST_UP;
						end else begin
							ptr_q <= ptr_q + IDX_W'(1);
						end
					end
				end
				ST_UP: begin
					if (!rising_q[ptr_q]) begin
						state_q <= ST_DN;
					end else if (roll_up) begin
						step_q[ptr_q]   <= '0;
						rising_q[ptr_q] <= 1'b0;
						used_q          <= used_up_roll[BUDGET_W-1:0];
						state_q         <= ST_DN;
					end else begin
						step_q[ptr_q] <= up_cnt;
						used_q        <= used_inc[BUDGET_W-1:0];
						state_q       <= ST_IDLE;
					end
				end
				ST_DN: begin
					if (roll_dn) begin
						step_q[ptr_q]   <= '0;
						rising_q[ptr_q] <= 1'b1;
						used_q          <= used_dn_roll[BUDGET_W-1:0];
						if (ptr_q != last_idx) begin
							ptr_q   <= ptr_q + IDX_W'(1);
							state_q <= ST_UP;
						end else begin
							done_q  <= 1'b1;
							ptr_q   <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						step_q[ptr_q] <= cur - CNT_W'(1);
						used_q        <= used_inc[BUDGET_W-1:0];
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_step  = out_step_q;
	assign out_last  = out_last_q;
	assign out_exh   = out_exh_q;

endmodule

// ----- src/bounded_l1_ball_lattice_enumerator.sv -----
`timescale 1ns / 1ps
// channel  dir  beat fields
// s_*      in   command: operation, coord_index, upper_steps, lower_steps
// m_*      out  result: out_index, step_count; tlast = last; tuser = exhausted
// cfg_*    in   register write: cfg_index selects, cfg_data carries value
//
// Load and restart are handled in the back-end idle state. An emit takes a dispatch
// step, one beat per coordinate in use, then the up and/or down half of each odometer
// digit the carry reaches, one digit at a time through the single shared digit update.
// An emit after the walk is done sends a lone exhausted beat; beats wait on m_tready.
// A two-entry command queue takes two beats while results stall, then s_tready drops.
// Reset clears the walk at once; coordinate limits hold nothing until loaded.
module bounded_l1_ball_lattice_enumerator
	import bl1e_pkg::*;
#(
	parameter int COORDS     = DEF_COORDS,
	parameter int STEP_WIDTH = DEF_STEP_WIDTH,
	parameter int IDX_W      = (COORDS > 1) ? $clog2(COORDS) : 1,
	parameter int IN_W       = ((KIND_W + IDX_W + 2 * STEP_WIDTH + 7) / 8) * 8,
	parameter int OUT_W      = ((IDX_W + STEP_WIDTH + 1 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,  // operation, coord_index, upper_steps, lower_steps
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // out_index, step_count
	output logic                  m_tlast,
	output logic                  m_tuser,  // exhausted
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMD_W = KIND_W + IDX_W + 2 * STEP_WIDTH;

	cfg_t              cfg_q;
	logic              q_full;
	logic              q_push;
	logic [CMD_W-1:0]  q_in;
	logic              q_valid;
	logic              q_pop;
	logic [CMD_W-1:0]  q_out;
	logic [IDX_W-1:0]  res_index;
	logic [STEP_WIDTH:0] res_step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_count  <= GROUP_RESET;
			cfg_q.budget_steps <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GROUP:  cfg_q.group_count  <= cfg_data[GROUP_W-1:0];
				REG_BUDGET: cfg_q.budget_steps <= cfg_data[BUDGET_W-1:0];
				default: ;
			endcase
		end
	end

	bl1e_front #(
		.COORDS     (COORDS),
		.STEP_WIDTH (STEP_WIDTH),
		.IDX_W      (IDX_W),
		.IN_W       (IN_W),
		.CMD_W      (CMD_W)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	bl1e_cmd_fifo #(
		.WIDTH (CMD_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_out)
	);

	bl1e_back #(
		.COORDS     (COORDS),
		.STEP_WIDTH (STEP_WIDTH),
		.IDX_W      (IDX_W),
		.CMD_W      (CMD_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd_data  (q_out),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (res_index),
		.out_step  (res_step),
		.out_last  (m_tlast),
		.out_exh   (m_tuser)
	);

	assign m_tdata = OUT_W'({res_step, res_index});

endmodule

// ----- src/bl1e_checker.sv -----
`timescale 1ns / 1ps
`include "bounded_l1_ball_lattice_enumerator_assert.svh"
module bl1e_checker
	import bl1e_pkg::*;
#(
	parameter int COORDS     = DEF_COORDS,
	parameter int STEP_WIDTH = DEF_STEP_WIDTH,
	parameter int IDX_W      = (COORDS > 1) ? $clog2(COORDS) : 1,
	parameter int OUT_W      = ((IDX_W + STEP_WIDTH + 1 + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_W-1:0]      m_tdata,
	input logic                  m_tlast,
	input logic                  m_tuser,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	`BL1E_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
		"result beat changed while stalled")
	`BL1E_ASSERT_NOW(a_exh_form, m_tvalid && m_tuser, m_tlast && (m_tdata == '0),
		"exhausted beat is not a lone zero beat")
	`BL1E_ASSERT_NOW(a_mid_beat, m_tvalid && !m_tlast, !m_tuser,
		"exhausted flag on a non-final beat")
	`BL1E_ASSERT_NOW(a_index_range, m_tvalid, 32'(m_tdata[IDX_W-1:0]) < 32'(COORDS),
		"result index past last coordinate")
	`BL1E_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready,
		"configuration beat stalled")

endmodule

bind bounded_l1_ball_lattice_enumerator bl1e_checker #(
	.COORDS     (COORDS),
	.STEP_WIDTH (STEP_WIDTH)
) u_bl1e_checker (.*);
